// ----- hw/rtl/tcep_pkg.sv -----
// ---------------------------------------------------------------------------
// tcep_pkg - shared definitions of the text color escape parser
// Widths, character codes, register indexes, the glyph record and the palette.
// ---------------------------------------------------------------------------
package tcep_pkg;

    // sizes
    localparam int COUNT_BITS = 16;
    localparam int COORD_BITS = 16;
    localparam int CHAR_BITS  = 8;
    localparam int FIELD_XY_BITS = 16;
    localparam int COLOR_BITS = 8;
    localparam int ADV_BITS   = 8;
    localparam int HEX_CNT_BITS = 3;
    localparam int HEX_ACC_BITS = 24;
    localparam int HEX_DIGITS   = 6;

    // sum 2*x + count*advance, wide enough for the shadow offset and the clamp
    localparam int PROD_BITS = COUNT_BITS + ADV_BITS;
    localparam int SUM_BASE  = (PROD_BITS + 1 > FIELD_XY_BITS + 1) ?
                               PROD_BITS + 1 : FIELD_XY_BITS + 1;
    localparam int SUM_WIDE  = (SUM_BASE > COORD_BITS) ? SUM_BASE : COORD_BITS;
    localparam int SUM_BITS  = SUM_WIDE + 2;

    // character codes
    localparam logic [CHAR_BITS-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CHAR_CARET   = 8'h5E;
    localparam logic [CHAR_BITS-1:0] CHAR_HEX     = 8'h3E;
    localparam logic [CHAR_BITS-1:0] CHAR_SHADOW  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CHAR_BOLD    = 8'h26;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_LOW_A   = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LOW_F   = 8'h66;
    localparam logic [CHAR_BITS-1:0] CHAR_LOW_L   = 8'h6C;
    localparam logic [CHAR_BITS-1:0] CHAR_UP_A    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UP_F    = 8'h46;
    localparam logic [CHAR_BITS-1:0] CASE_BIT     = 8'h20;

    // colors
    localparam logic [3*COLOR_BITS-1:0] COLOR_YELLOW = 24'hFFFF00;
    localparam logic [COLOR_BITS-1:0]   COLOR_RESET  = 8'd220;
    localparam logic [ADV_BITS-1:0]     ADV_RESET    = 8'd17;
    localparam int SHADOW_OFFSET = 2;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_RED   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_GREEN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_BLUE  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ADVANCE       = 2'd3;

    localparam int PALETTE_INDEX_BITS = 5;

    // one glyph to be drawn, handed from parser to emitter
    typedef struct packed {
        logic [CHAR_BITS-1:0]         code;
        logic [COUNT_BITS-1:0]        count;
        logic signed [FIELD_XY_BITS-1:0] start_x;
        logic signed [FIELD_XY_BITS-1:0] start_y;
        logic [COLOR_BITS-1:0]        red;
        logic [COLOR_BITS-1:0]        green;
        logic [COLOR_BITS-1:0]        blue;
        logic                         shadow;
    } glyph_rec_t;

    // palette lookup, {red, green, blue}
    function automatic logic [3*COLOR_BITS-1:0] palette_color(
        input logic [PALETTE_INDEX_BITS-1:0] idx
    );
        logic [3*COLOR_BITS-1:0] rgb;
        case (idx)
            5'd0:    rgb = {8'd0,   8'd0,   8'd0};
            5'd1:    rgb = {8'd255, 8'd255, 8'd255};
            5'd2:    rgb = {8'd0,   8'd0,   8'd255};
            5'd3:    rgb = {8'd0,   8'd255, 8'd0};
            5'd4:    rgb = {8'd255, 8'd0,   8'd0};
            5'd5:    rgb = {8'd0,   8'd255, 8'd255};
            5'd6:    rgb = {8'd255, 8'd255, 8'd0};
            5'd7:    rgb = {8'd255, 8'd0,   8'd255};
            5'd8:    rgb = {8'd100, 8'd0,   8'd255};
            5'd9:    rgb = {8'd100, 8'd255, 8'd0};
            5'd10:   rgb = {8'd255, 8'd0,   8'd100};
            5'd11:   rgb = {8'd100, 8'd255, 8'd100};
            5'd12:   rgb = {8'd200, 8'd200, 8'd200};
            5'd13:   rgb = {8'd150, 8'd150, 8'd150};
            5'd14:   rgb = {8'd100, 8'd100, 8'd100};
            5'd15:   rgb = {8'd50,  8'd50,  8'd50};
            5'd16:   rgb = {8'd50,  8'd0,   8'd0};
            5'd17:   rgb = {8'd0,   8'd50,  8'd0};
            5'd18:   rgb = {8'd0,   8'd0,   8'd50};
            5'd19:   rgb = {8'd50,  8'd0,   8'd50};
            5'd20:   rgb = {8'd50,  8'd50,  8'd0};
            5'd21:   rgb = {8'd0,   8'd50,  8'd50};
            default: rgb = {8'd0,   8'd0,   8'd0};
        endcase
        return rgb;
    endfunction

endpackage

// ----- hw/rtl/tcep_ifs.sv -----
// ---------------------------------------------------------------------------
// tcep_ifs - stream channels of the text color escape parser
// Input byte channel and glyph result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface tcep_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_code;
    logic        first_of_string;
    logic        last_of_string;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;

    modport source (
        output valid, char_code, first_of_string, last_of_string, origin_x, origin_y,
        input  ready
    );
    modport sink (
        input  valid, char_code, first_of_string, last_of_string, origin_x, origin_y,
        output ready
    );
endinterface

interface tcep_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  glyph_code;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        is_shadow;
    logic        last_of_run;

    modport source (
        output valid, glyph_code, pos_x, pos_y, red, green, blue, is_shadow, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, glyph_code, pos_x, pos_y, red, green, blue, is_shadow, last_of_run,
        output ready
    );
endinterface

// ----- hw/rtl/tcep_parser.sv -----
// ---------------------------------------------------------------------------
// tcep_parser - escape decoder and string state
// Decodes one byte per transfer, keeps color, shadow, count and origin, and
// registers a glyph record for every byte that draws.
// ---------------------------------------------------------------------------
module tcep_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    tcep_in_if.sink                        in_ch,
    input  logic [tcep_pkg::COLOR_BITS-1:0] default_red,
    input  logic [tcep_pkg::COLOR_BITS-1:0] default_green,
    input  logic [tcep_pkg::COLOR_BITS-1:0] default_blue,
    output logic                           rec_valid,
    input  logic                           rec_ready,
    output tcep_pkg::glyph_rec_t           rec
);

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_CARET,
        MODE_HEX,
        MODE_HALT
    } mode_t;

    localparam logic [tcep_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    mode_t                                  mode_reg, mode_cur, mode_next;
    logic [tcep_pkg::HEX_CNT_BITS-1:0]      hex_cnt_reg, hex_cnt_cur, hex_cnt_next;
    logic [tcep_pkg::HEX_ACC_BITS-1:0]      hex_acc_reg, hex_acc_cur, hex_acc_next;
    logic [tcep_pkg::COLOR_BITS-1:0]        red_reg, red_next;
    logic [tcep_pkg::COLOR_BITS-1:0]        green_reg, green_next;
    logic [tcep_pkg::COLOR_BITS-1:0]        blue_reg, blue_next;
    logic                                   shadow_reg, shadow_next;
    logic [tcep_pkg::COUNT_BITS-1:0]        count_reg, count_next;
    logic signed [tcep_pkg::FIELD_XY_BITS-1:0] start_x_reg, start_x_next;
    logic signed [tcep_pkg::FIELD_XY_BITS-1:0] start_y_reg, start_y_next;
    logic                                   rec_valid_reg, rec_valid_next;
    tcep_pkg::glyph_rec_t                   rec_reg, rec_next;

    logic                                   accept;
    logic                                   draw;
    logic [tcep_pkg::CHAR_BITS-1:0]         c;
    logic [tcep_pkg::CHAR_BITS-1:0]         lc;
    logic [3*tcep_pkg::COLOR_BITS-1:0]      pal_rgb;
    logic [tcep_pkg::PALETTE_INDEX_BITS-1:0] pal_idx;

    // hex digit value, anything else counts as zero
    function automatic logic [3:0] hex_value(input logic [tcep_pkg::CHAR_BITS-1:0] ch);
        logic [3:0] v;
        v = 4'd0;
        if (ch >= tcep_pkg::CHAR_ZERO && ch <= tcep_pkg::CHAR_NINE)
            v = 4'(ch - tcep_pkg::CHAR_ZERO);
        else if (ch >= tcep_pkg::CHAR_LOW_A && ch <= tcep_pkg::CHAR_LOW_F)
            v = 4'(ch - tcep_pkg::CHAR_LOW_A + 8'd10);
        else if (ch >= tcep_pkg::CHAR_UP_A && ch <= tcep_pkg::CHAR_UP_F)
            v = 4'(ch - tcep_pkg::CHAR_UP_A + 8'd10);
        return v;
    endfunction

    assign in_ch.ready = !rec_valid_reg || rec_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign rec_valid   = rec_valid_reg;
    assign rec         = rec_reg;

    // palette index from a digit or a letter
    assign c  = in_ch.char_code;
    assign lc = c | tcep_pkg::CASE_BIT;
    always_comb
    begin
        if (c >= tcep_pkg::CHAR_ZERO && c <= tcep_pkg::CHAR_NINE)
            pal_idx = tcep_pkg::PALETTE_INDEX_BITS'(c - tcep_pkg::CHAR_ZERO);
        else
            pal_idx = tcep_pkg::PALETTE_INDEX_BITS'(lc - tcep_pkg::CHAR_LOW_A + 8'd10);
    end
    assign pal_rgb = tcep_pkg::palette_color(pal_idx);

    // byte decode and next string state
    always_comb
    begin
        mode_cur     = mode_reg;
        hex_cnt_cur  = hex_cnt_reg;
        hex_acc_cur  = hex_acc_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        shadow_next  = shadow_reg;
        count_next   = count_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        draw         = 1'b0;

        // start of a string
        if (in_ch.first_of_string)
        begin
            mode_cur     = MODE_NORMAL;
            hex_cnt_cur  = '0;
            hex_acc_cur  = '0;
            red_next     = default_red;
            green_next   = default_green;
            blue_next    = default_blue;
            shadow_next  = 1'b0;
            count_next   = '0;
            start_x_next = in_ch.origin_x;
            start_y_next = in_ch.origin_y;
        end

        mode_next    = mode_cur;
        hex_cnt_next = hex_cnt_cur;
        hex_acc_next = hex_acc_cur;

        unique case (mode_cur)
            MODE_NORMAL:
            begin
                if (c == tcep_pkg::CHAR_NUL)
                    mode_next = MODE_HALT;
                else if (c == tcep_pkg::CHAR_CARET)
                    mode_next = MODE_CARET;
                else
                    draw = 1'b1;
            end
            MODE_CARET:
            begin
                mode_next = MODE_NORMAL;
                if (c == tcep_pkg::CHAR_NUL || c == tcep_pkg::CHAR_NEWLINE)
                    mode_next = MODE_HALT;
                else if ((c >= tcep_pkg::CHAR_ZERO && c <= tcep_pkg::CHAR_NINE) ||
                         (lc >= tcep_pkg::CHAR_LOW_A && lc <= tcep_pkg::CHAR_LOW_L))
                    {red_next, green_next, blue_next} = pal_rgb;
                else if (c == tcep_pkg::CHAR_HEX)
                begin
                    mode_next    = MODE_HEX;
                    hex_cnt_next = '0;
                    hex_acc_next = '0;
                end
                else if (c == tcep_pkg::CHAR_CARET)
                    draw = 1'b1;
                else if (c == tcep_pkg::CHAR_SHADOW)
                    shadow_next = !shadow_next;
                else if (c == tcep_pkg::CHAR_BOLD)
                    mode_next = MODE_NORMAL;
                else
                    {red_next, green_next, blue_next} = tcep_pkg::COLOR_YELLOW;
            end
            MODE_HEX:
            begin
                if (c == tcep_pkg::CHAR_NUL)
                    mode_next = MODE_HALT;
                else
                begin
                    hex_acc_next = {hex_acc_cur[tcep_pkg::HEX_ACC_BITS-5:0], hex_value(c)};
                    hex_cnt_next = hex_cnt_cur + 3'd1;
                    if (hex_cnt_next >= tcep_pkg::HEX_CNT_BITS'(tcep_pkg::HEX_DIGITS))
                    begin
                        {red_next, green_next, blue_next} = hex_acc_next;
                        hex_cnt_next = '0;
                        mode_next    = MODE_NORMAL;
                    end
                end
            end
            MODE_HALT:
            begin
                mode_next = MODE_HALT;
            end
            default:
            begin
                mode_next = MODE_NORMAL;
            end
        endcase

        // count saturates at its maximum
        if (draw && count_next != COUNT_MAX)
            count_next = count_next + 1'b1;

        // unfinished escapes end with the string
        if (in_ch.last_of_string)
        begin
            mode_next    = MODE_NORMAL;
            hex_cnt_next = '0;
            hex_acc_next = '0;
        end
    end

    // glyph record register
    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        rec_next       = rec_reg;
        if (rec_ready)
            rec_valid_next = 1'b0;
        if (accept && draw)
        begin
            rec_valid_next   = 1'b1;
            rec_next.code    = c;
            rec_next.count   = count_next;
            rec_next.start_x = start_x_next;
            rec_next.start_y = start_y_next;
            rec_next.red     = red_next;
            rec_next.green   = green_next;
            rec_next.blue    = blue_next;
            rec_next.shadow  = shadow_next;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            hex_cnt_reg   <= '0;
            hex_acc_reg   <= '0;
            red_reg       <= tcep_pkg::COLOR_RESET;
            green_reg     <= tcep_pkg::COLOR_RESET;
            blue_reg      <= tcep_pkg::COLOR_RESET;
            shadow_reg    <= 1'b0;
            count_reg     <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
            if (accept)
            begin
                mode_reg    <= mode_next;
                hex_cnt_reg <= hex_cnt_next;
                hex_acc_reg <= hex_acc_next;
                red_reg     <= red_next;
                green_reg   <= green_next;
                blue_reg    <= blue_next;
                shadow_reg  <= shadow_next;
                count_reg   <= count_next;
                start_x_reg <= start_x_next;
                start_y_reg <= start_y_next;
            end
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

// ----- hw/rtl/tcep_emitter.sv -----
// ---------------------------------------------------------------------------
// tcep_emitter - glyph position and result output
// Turns a glyph record into a shadow copy (when enabled) and a main result,
// computing the half-pixel position, truncation toward zero and the clamp.
// ---------------------------------------------------------------------------
module tcep_emitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcep_pkg::ADV_BITS-1:0] advance,
    input  logic                          rec_valid,
    output logic                          rec_ready,
    input  tcep_pkg::glyph_rec_t          rec,
    tcep_out_if.source                    out_ch
);

    localparam int SB = tcep_pkg::SUM_BITS;
    localparam int XY = tcep_pkg::FIELD_XY_BITS;
    localparam logic signed [SB-1:0] SAT_HI = SB'((64'sd1 <<< (tcep_pkg::COORD_BITS - 1)) - 1);
    localparam logic signed [SB-1:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [SB-1:0] OFS_HALF = SB'(2 * tcep_pkg::SHADOW_OFFSET);
    localparam logic signed [SB-1:0] OFS_FULL = SB'(tcep_pkg::SHADOW_OFFSET);

    typedef struct packed {
        logic [tcep_pkg::CHAR_BITS-1:0]  glyph_code;
        logic signed [XY-1:0]            pos_x;
        logic signed [XY-1:0]            pos_y;
        logic [tcep_pkg::COLOR_BITS-1:0] red;
        logic [tcep_pkg::COLOR_BITS-1:0] green;
        logic [tcep_pkg::COLOR_BITS-1:0] blue;
        logic                            is_shadow;
        logic                            last_of_run;
    } out_item_t;

    logic                               out_valid_reg, out_valid_next;
    out_item_t                          out_reg, out_next;
    logic                               phase_reg, phase_next;
    logic                               load;
    logic                               emit_shadow;
    logic [tcep_pkg::PROD_BITS-1:0]     prod;
    logic signed [SB-1:0]               sum2;
    logic signed [SB-1:0]               y_ext;

    // halve toward zero
    function automatic logic signed [SB-1:0] half_trunc(input logic signed [SB-1:0] v);
        logic [SB-1:0] t;
        t = v + {{(SB-1){1'b0}}, v[SB-1]};
        return $signed(t) >>> 1;
    endfunction

    // clamp to the coordinate range, keep the field bits
    function automatic logic signed [XY-1:0] clamp(input logic signed [SB-1:0] v);
        logic signed [SB-1:0] t;
        t = v;
        if (v > SAT_HI)
            t = SAT_HI;
        else if (v < SAT_LO)
            t = SAT_LO;
        return t[XY-1:0];
    endfunction

    // position in half pixels
    assign prod  = rec.count * advance;
    assign sum2  = {{(SB-XY-1){rec.start_x[XY-1]}}, rec.start_x, 1'b0}
                 + {{(SB-tcep_pkg::PROD_BITS){1'b0}}, prod};
    assign y_ext = {{(SB-XY){rec.start_y[XY-1]}}, rec.start_y};

    assign load        = rec_valid && (!out_valid_reg || out_ch.ready);
    assign emit_shadow = rec.shadow && !phase_reg;
    assign rec_ready   = load && !emit_shadow;

    // next result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        phase_next     = phase_reg;
        if (out_ch.ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next      = 1'b1;
            out_next.glyph_code = rec.code;
            if (emit_shadow)
            begin
                out_next.pos_x       = clamp(half_trunc(sum2 + OFS_HALF));
                out_next.pos_y       = clamp(y_ext + OFS_FULL);
                out_next.red         = '0;
                out_next.green       = '0;
                out_next.blue        = '0;
                out_next.is_shadow   = 1'b1;
                out_next.last_of_run = 1'b0;
                phase_next           = 1'b1;
            end
            else
            begin
                out_next.pos_x       = clamp(half_trunc(sum2));
                out_next.pos_y       = clamp(y_ext);
                out_next.red         = rec.red;
                out_next.green       = rec.green;
                out_next.blue        = rec.blue;
                out_next.is_shadow   = 1'b0;
                out_next.last_of_run = 1'b1;
                phase_next           = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.glyph_code  = out_reg.glyph_code;
    assign out_ch.pos_x       = out_reg.pos_x;
    assign out_ch.pos_y       = out_reg.pos_y;
    assign out_ch.red         = out_reg.red;
    assign out_ch.green       = out_reg.green;
    assign out_ch.blue        = out_reg.blue;
    assign out_ch.is_shadow   = out_reg.is_shadow;
    assign out_ch.last_of_run = out_reg.last_of_run;

endmodule

// ----- hw/rtl/text_color_escape_parser_top.sv -----
// ---------------------------------------------------------------------------
// text_color_escape_parser_top - text escape parser, top level
// Parses caret escapes in a text byte stream and emits glyph draw results.
//
//   channel   dir  transfer item
//   in_ch     in   one text byte with string flags and origin
//   out_ch    out  one glyph: code, position, color, shadow and run flags
//   cfg       in   write of a default color or the glyph advance
//
// A byte is taken every cycle while the record register can take it; a byte
// that draws a shadowed glyph holds the emitter for its shadow and main results.
// A result passes the parser's record register, then the emitter's result register.
// Reset clears the parse state and sets the registers to their defaults.
// A stalled output holds its result while one more glyph waits in the record
// register; only then is the input stalled.
// ---------------------------------------------------------------------------
module text_color_escape_parser_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tcep_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tcep_pkg::COLOR_BITS-1:0]     cfg_data,
    tcep_in_if.sink                             in_ch,
    tcep_out_if.source                          out_ch
);

    logic [tcep_pkg::COLOR_BITS-1:0] def_red_reg;
    logic [tcep_pkg::COLOR_BITS-1:0] def_green_reg;
    logic [tcep_pkg::COLOR_BITS-1:0] def_blue_reg;
    logic [tcep_pkg::ADV_BITS-1:0]   advance_reg;

    logic                 rec_valid;
    logic                 rec_ready;
    tcep_pkg::glyph_rec_t rec;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_red_reg   <= tcep_pkg::COLOR_RESET;
            def_green_reg <= tcep_pkg::COLOR_RESET;
            def_blue_reg  <= tcep_pkg::COLOR_RESET;
            advance_reg   <= tcep_pkg::ADV_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcep_pkg::CFG_DEFAULT_RED:   def_red_reg   <= cfg_data;
                tcep_pkg::CFG_DEFAULT_GREEN: def_green_reg <= cfg_data;
                tcep_pkg::CFG_DEFAULT_BLUE:  def_blue_reg  <= cfg_data;
                tcep_pkg::CFG_ADVANCE:       advance_reg   <= cfg_data;
                default:                     advance_reg   <= advance_reg;
            endcase
        end
    end

    // byte decode
    tcep_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .default_red   (def_red_reg),
        .default_green (def_green_reg),
        .default_blue  (def_blue_reg),
        .rec_valid     (rec_valid),
        .rec_ready     (rec_ready),
        .rec           (rec)
    );

    // glyph results
    tcep_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance_reg),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .out_ch    (out_ch)
    );

endmodule

// ----- tb/sv/tcep_glyph_checker.sv -----
// ---------------------------------------------------------------------------
// tcep_glyph_checker - glyph predictor and scoreboard of the escape parser
// Watches the byte and glyph channels and the register write port, keeps its
// own copy of the parse state, predicts the glyphs of every byte transfer and
// compares each glyph transfer field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tcep_glyph_checker
    import tcep_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COLOR_BITS-1:0]     cfg_data,
    tcep_in_if                        in_ch,
    tcep_out_if                       out_ch,
    output int                        fail_count,
    output int                        pending
);

    typedef enum logic [1:0] {
        PM_NORMAL,
        PM_CARET,
        PM_HEX,
        PM_HALT
    } parse_mode_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0]            code;
        logic signed [FIELD_XY_BITS-1:0] x;
        logic signed [FIELD_XY_BITS-1:0] y;
        logic [COLOR_BITS-1:0]           red;
        logic [COLOR_BITS-1:0]           green;
        logic [COLOR_BITS-1:0]           blue;
        logic                            shadow;
        logic                            last;
    } glyph_t;

    // palette colors, {red, green, blue}
    localparam logic [3*COLOR_BITS-1:0] PALETTE_RGB [0:21] = '{
        24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h00FFFF,
        24'hFFFF00, 24'hFF00FF, 24'h6400FF, 24'h64FF00, 24'hFF0064, 24'h64FF64,
        24'hC8C8C8, 24'h969696, 24'h646464, 24'h323232, 24'h320000, 24'h003200,
        24'h000032, 24'h320032, 24'h323200, 24'h003232
    };

    // register copies
    logic [COLOR_BITS-1:0] dflt_red;
    logic [COLOR_BITS-1:0] dflt_green;
    logic [COLOR_BITS-1:0] dflt_blue;
    logic [ADV_BITS-1:0]   advance;

    // parse state copy
    parse_mode_t                     mode;
    logic [HEX_CNT_BITS-1:0]         hex_cnt;
    logic [HEX_ACC_BITS-1:0]         hex_acc;
    logic [COLOR_BITS-1:0]           cur_red;
    logic [COLOR_BITS-1:0]           cur_green;
    logic [COLOR_BITS-1:0]           cur_blue;
    logic                            shadow_on;
    logic [COUNT_BITS-1:0]           glyph_cnt;
    logic signed [FIELD_XY_BITS-1:0] org_x;
    logic signed [FIELD_XY_BITS-1:0] org_y;

    glyph_t expected_glyphs [$];
    int     glyphs_seen;

    // one line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        $display("glyph %0d: %s", glyphs_seen, msg);
        fail_count++;
    endtask

    function automatic logic signed [FIELD_XY_BITS-1:0] clamp_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return FIELD_XY_BITS'(hi);
        if (v < lo)
            return FIELD_XY_BITS'(lo);
        return FIELD_XY_BITS'(v);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [CHAR_BITS-1:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return 4'(c - CHAR_ZERO);
        if (c >= CHAR_LOW_A && c <= CHAR_LOW_F)
            return 4'(c - CHAR_LOW_A + 10);
        if (c >= CHAR_UP_A && c <= CHAR_UP_F)
            return 4'(c - CHAR_UP_A + 10);
        // a bad digit counts as zero
        return 4'd0;
    endfunction

    // count the glyph, then queue the shadow copy (when shadow is on) and the colored glyph
    task automatic emit_glyph(input logic [CHAR_BITS-1:0] c);
        longint twice_x;
        glyph_t g;
        if (glyph_cnt != {COUNT_BITS{1'b1}})
            glyph_cnt++;
        twice_x = 2 * longint'(org_x) + longint'(glyph_cnt) * longint'(advance);
        if (shadow_on)
        begin
            g.code   = c;
            g.x      = clamp_coord((twice_x + 2 * SHADOW_OFFSET) / 2);
            g.y      = clamp_coord(longint'(org_y) + SHADOW_OFFSET);
            g.red    = '0;
            g.green  = '0;
            g.blue   = '0;
            g.shadow = 1'b1;
            g.last   = 1'b0;
            expected_glyphs.push_back(g);
        end
        g.code   = c;
        g.x      = clamp_coord(twice_x / 2);
        g.y      = org_y;
        g.red    = cur_red;
        g.green  = cur_green;
        g.blue   = cur_blue;
        g.shadow = 1'b0;
        g.last   = 1'b1;
        expected_glyphs.push_back(g);
    endtask

    // advance the parse state by one byte
    task automatic predict_byte(
        input logic [CHAR_BITS-1:0]            c,
        input logic                            first,
        input logic                            last,
        input logic signed [FIELD_XY_BITS-1:0] ox,
        input logic signed [FIELD_XY_BITS-1:0] oy
    );
        logic [CHAR_BITS-1:0] folded;
        folded = c | CASE_BIT;
        if (first)
        begin
            mode      = PM_NORMAL;
            hex_cnt   = '0;
            hex_acc   = '0;
            cur_red   = dflt_red;
            cur_green = dflt_green;
            cur_blue  = dflt_blue;
            shadow_on = 1'b0;
            glyph_cnt = '0;
            org_x     = ox;
            org_y     = oy;
        end
        case (mode)
            PM_NORMAL:
            begin
                if (c == CHAR_NUL)
                    mode = PM_HALT;
                else if (c == CHAR_CARET)
                    mode = PM_CARET;
                else
                    emit_glyph(c);
            end
            PM_CARET:
            begin
                mode = PM_NORMAL;
                if (c == CHAR_NUL || c == CHAR_NEWLINE)
                    mode = PM_HALT;
                else if (c >= CHAR_ZERO && c <= CHAR_NINE)
                    {cur_red, cur_green, cur_blue} = PALETTE_RGB[c - CHAR_ZERO];
                else if (folded >= CHAR_LOW_A && folded <= CHAR_LOW_L)
                    {cur_red, cur_green, cur_blue} = PALETTE_RGB[folded - CHAR_LOW_A + 10];
                else if (c == CHAR_HEX)
                begin
                    mode    = PM_HEX;
                    hex_cnt = '0;
                    hex_acc = '0;
                end
                else if (c == CHAR_CARET)
                    emit_glyph(c);
                else if (c == CHAR_SHADOW)
                    shadow_on = !shadow_on;
                else if (c != CHAR_BOLD)
                    {cur_red, cur_green, cur_blue} = COLOR_YELLOW;
            end
            PM_HEX:
            begin
                if (c == CHAR_NUL)
                    mode = PM_HALT;
                else
                begin
                    hex_acc = {hex_acc[HEX_ACC_BITS-5:0], hex_nibble(c)};
                    hex_cnt++;
                    if (hex_cnt >= HEX_DIGITS)
                    begin
                        {cur_red, cur_green, cur_blue} = hex_acc;
                        hex_cnt = '0;
                        mode    = PM_NORMAL;
                    end
                end
            end
            default:
            begin
            end
        endcase
        // an unfinished escape is dropped at the end of the string
        if (last)
        begin
            mode    = PM_NORMAL;
            hex_cnt = '0;
            hex_acc = '0;
        end
    endtask

    // compare one glyph transfer against the oldest prediction
    task automatic check_glyph();
        glyph_t want;
        if (expected_glyphs.size() == 0)
        begin
            report_mismatch($sformatf("unexpected glyph, code %0d at (%0d,%0d)",
                                      out_ch.glyph_code, out_ch.pos_x, out_ch.pos_y));
        end
        else
        begin
            want = expected_glyphs.pop_front();
            if (out_ch.glyph_code !== want.code)
                report_mismatch($sformatf("glyph_code got %0d, expected %0d",
                                          out_ch.glyph_code, want.code));
            if (out_ch.pos_x !== want.x)
                report_mismatch($sformatf("pos_x got %0d, expected %0d",
                                          out_ch.pos_x, want.x));
            if (out_ch.pos_y !== want.y)
                report_mismatch($sformatf("pos_y got %0d, expected %0d",
                                          out_ch.pos_y, want.y));
            if (out_ch.red !== want.red)
                report_mismatch($sformatf("red got %0d, expected %0d",
                                          out_ch.red, want.red));
            if (out_ch.green !== want.green)
                report_mismatch($sformatf("green got %0d, expected %0d",
                                          out_ch.green, want.green));
            if (out_ch.blue !== want.blue)
                report_mismatch($sformatf("blue got %0d, expected %0d",
                                          out_ch.blue, want.blue));
            if (out_ch.is_shadow !== want.shadow)
                report_mismatch($sformatf("is_shadow got %0d, expected %0d",
                                          out_ch.is_shadow, want.shadow));
            if (out_ch.last_of_run !== want.last)
                report_mismatch($sformatf("last_of_run got %0d, expected %0d",
                                          out_ch.last_of_run, want.last));
        end
        glyphs_seen++;
    endtask

    // register writes, byte transfers and glyph transfers at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_red    = COLOR_RESET;
            dflt_green  = COLOR_RESET;
            dflt_blue   = COLOR_RESET;
            advance     = ADV_RESET;
            mode        = PM_NORMAL;
            hex_cnt     = '0;
            hex_acc     = '0;
            cur_red     = COLOR_RESET;
            cur_green   = COLOR_RESET;
            cur_blue    = COLOR_RESET;
            shadow_on   = 1'b0;
            glyph_cnt   = '0;
            org_x       = '0;
            org_y       = '0;
            glyphs_seen = 0;
            fail_count  = 0;
            pending     = 0;
            expected_glyphs.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEFAULT_RED:   dflt_red   = cfg_data;
                    CFG_DEFAULT_GREEN: dflt_green = cfg_data;
                    CFG_DEFAULT_BLUE:  dflt_blue  = cfg_data;
                    CFG_ADVANCE:       advance    = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                predict_byte(in_ch.char_code, in_ch.first_of_string, in_ch.last_of_string,
                             in_ch.origin_x, in_ch.origin_y);
            if (out_ch.valid && out_ch.ready)
                check_glyph();
            pending = expected_glyphs.size();
        end
    end

endmodule

// ----- tb/sv/tb_text_color_escape_parser_top.sv -----
// ---------------------------------------------------------------------------
// tb_text_color_escape_parser_top - testbench of the text escape parser
// Drives text strings with caret escapes through the byte channel: a short
// directed set, then random strings under several register settings. Both
// sides idle at random; the glyph side also holds off for long stretches.
// A checker beside the block predicts and compares every glyph.
// ---------------------------------------------------------------------------
module tb_text_color_escape_parser_top;
    import tcep_pkg::*;

    localparam int IDLE_PCT      = 7;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 200;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [COLOR_BITS-1:0]     cfg_data;

    int fail_count;
    int pending;

    // idling control and long hold-off requests toward the glyph side
    logic quiet = 1'b0;
    int   hold_asks = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    logic [CHAR_BITS-1:0] text_q [$];
    int                   phase_items;

    tcep_in_if  in_ch ();
    tcep_out_if out_ch ();

    text_color_escape_parser_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    tcep_glyph_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    // glyph side: random stalls, plus a long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= (quiet ? 0 : IDLE_PCT));
        end
    end

    // one byte transfer, entered and left at a falling edge
    task automatic send_byte(
        input logic [CHAR_BITS-1:0]            c,
        input logic                            first,
        input logic                            last,
        input logic signed [FIELD_XY_BITS-1:0] ox,
        input logic signed [FIELD_XY_BITS-1:0] oy
    );
        while ($urandom_range(99) < (quiet ? 0 : IDLE_PCT))
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            @(negedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.char_code       <= c;
        in_ch.first_of_string <= first;
        in_ch.last_of_string  <= last;
        in_ch.origin_x        <= ox;
        in_ch.origin_y        <= oy;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(
        input string                           s,
        input logic                            first_on,
        input logic                            last_on,
        input logic signed [FIELD_XY_BITS-1:0] ox,
        input logic signed [FIELD_XY_BITS-1:0] oy
    );
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], first_on && i == 0, last_on && i == s.len() - 1, ox, oy);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [COLOR_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_registers(input logic [COLOR_BITS-1:0] r, g, b, adv);
        write_reg(CFG_DEFAULT_RED, r);
        write_reg(CFG_DEFAULT_GREEN, g);
        write_reg(CFG_DEFAULT_BLUE, b);
        write_reg(CFG_ADVANCE, adv);
        cfg_we <= 1'b0;
    endtask

    // stop offering, let every glyph drain and the pipeline go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [FIELD_XY_BITS-1:0] pick_coord();
        int r;
        r = $urandom_range(9);
        case (r)
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return FIELD_XY_BITS'($urandom_range(600) - 300);
            default: return FIELD_XY_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CHAR_BITS-1:0] pick_hex_digit();
        int k;
        k = $urandom_range(23);
        if (k < 10)
            return CHAR_ZERO + CHAR_BITS'(k);
        if (k < 16)
            return CHAR_LOW_A + CHAR_BITS'(k - 10);
        if (k < 22)
            return CHAR_UP_A + CHAR_BITS'(k - 16);
        // usually not a hex digit
        return CHAR_BITS'($urandom_range(1, 255));
    endfunction

    // append one plain byte or one escape sequence to the text
    task automatic add_token();
        int                   r;
        int                   k;
        logic [CHAR_BITS-1:0] b;
        r = $urandom_range(99);
        if (r < 45)
        begin
            b = CHAR_BITS'($urandom_range(32, 126));
            text_q.push_back(b);
        end
        else if (r < 55)
        begin
            b = CHAR_BITS'($urandom_range(1, 255));
            text_q.push_back(b);
        end
        else if (r < 65)
        begin
            // palette pick, letters in either case
            text_q.push_back(CHAR_CARET);
            k = $urandom_range(21);
            if (k < 10)
                b = CHAR_ZERO + CHAR_BITS'(k);
            else
                b = (CHAR_LOW_A + CHAR_BITS'(k - 10)) ^ ($urandom_range(1) ? CASE_BIT : '0);
            text_q.push_back(b);
        end
        else if (r < 75)
        begin
            text_q.push_back(CHAR_CARET);
            text_q.push_back(CHAR_HEX);
            repeat (HEX_DIGITS) text_q.push_back(pick_hex_digit());
        end
        else if (r < 80)
        begin
            text_q.push_back(CHAR_CARET);
            text_q.push_back(CHAR_CARET);
        end
        else if (r < 85)
        begin
            text_q.push_back(CHAR_CARET);
            text_q.push_back(CHAR_SHADOW);
        end
        else if (r < 88)
        begin
            text_q.push_back(CHAR_CARET);
            text_q.push_back(CHAR_BOLD);
        end
        else if (r < 93)
        begin
            b = CHAR_BITS'($urandom_range(1, 255));
            text_q.push_back(CHAR_CARET);
            text_q.push_back(b);
        end
        else if (r < 95)
        begin
            text_q.push_back(CHAR_CARET);
            text_q.push_back($urandom_range(1) ? CHAR_NEWLINE : CHAR_NUL);
        end
        else if (r < 97)
            text_q.push_back(CHAR_NUL);
        else
        begin
            // hex escape cut short
            text_q.push_back(CHAR_CARET);
            text_q.push_back(CHAR_HEX);
            repeat ($urandom_range(1, HEX_DIGITS - 1)) text_q.push_back(pick_hex_digit());
        end
    endtask

    // one random string, now and then without its first or last flag
    task automatic send_random_string();
        int                              tokens;
        logic                            with_first;
        logic                            with_last;
        logic                            last_flag;
        logic signed [FIELD_XY_BITS-1:0] ox;
        logic signed [FIELD_XY_BITS-1:0] oy;
        text_q.delete();
        tokens = $urandom_range(1, 8);
        repeat (tokens) add_token();
        with_first = ($urandom_range(99) < 92);
        with_last  = ($urandom_range(99) < 92);
        for (int i = 0; i < text_q.size(); i++)
        begin
            ox = pick_coord();
            oy = pick_coord();
            last_flag = (with_last && i == text_q.size() - 1) || ($urandom_range(99) < 2);
            send_byte(text_q[i], with_first && i == 0, last_flag, ox, oy);
            phase_items++;
        end
    endtask

    // stimulus and verdict
    initial
    begin
        logic hold_done;

        in_ch.valid           = 1'b0;
        in_ch.char_code       = '0;
        in_ch.first_of_string = 1'b0;
        in_ch.last_of_string  = 1'b0;
        in_ch.origin_x        = '0;
        in_ch.origin_y        = '0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_DEFAULT_RED;
        cfg_data              = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: shadow, palette digit and letter, caret caret, bold, other escape
        send_text("^+A^3^L^^^&^zB", 1'b1, 1'b1, 16'sh8000, 16'sh7FFF);
        // hex color with a bad digit, then the top code point
        send_text("^>Fx09ab", 1'b1, 1'b0, 16'sh7FFF, 16'sh8000);
        send_byte(8'hFF, 1'b0, 1'b1, '0, '0);
        // caret newline halts
        send_text("E^\nG", 1'b1, 1'b1, '0, '0);
        // NUL among hex digits halts
        send_text("^>1", 1'b1, 1'b0, 16'sd100, -16'sd5);
        send_byte(CHAR_NUL, 1'b0, 1'b0, '0, '0);
        send_text("H", 1'b0, 1'b1, '0, '0);
        // plain NUL halts
        send_byte(CHAR_NUL, 1'b1, 1'b0, -16'sd1, 16'sd1);
        send_text("K", 1'b0, 1'b1, '0, '0);

        // random strings under several register settings
        for (int p = 0; p < 4; p++)
        begin
            settle();
            case (p)
                0: set_registers(8'd0, 8'd0, 8'd0, 8'd1);
                1: set_registers(8'd255, 8'd255, 8'd255, 8'd255);
                default: set_registers(COLOR_BITS'($urandom), COLOR_BITS'($urandom),
                                       COLOR_BITS'($urandom),
                                       ADV_BITS'($urandom_range(1, 255)));
            endcase
            quiet <= (p == 1);
            phase_items = 0;
            hold_done = 1'b0;
            while (phase_items < PHASE_ITEMS)
            begin
                // long glyph-side hold-off while bytes keep coming
                if (!hold_done && phase_items >= 60 && (p == 0 || p == 2))
                begin
                    hold_asks <= hold_asks + 1;
                    hold_done = 1'b1;
                end
                send_random_string();
            end
        end

        settle();
        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
